[src/bss_pkg.sv]
package bss_pkg;

    // Field widths of the transfer payloads
    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE    = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the item and restart the scan
        logic scan;    // advance the read and compaction pipeline
        logic finish;  // commit the count, append, load the result
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

[src/bss_ram.sv]
module bss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with a registered output
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/bss_datapath.sv]
module bss_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bss_pkg::dp_cmd_t                     cmd,
    output bss_pkg::dp_stat_t                    stat,
    input  logic [bss_pkg::OP_W-1:0]             in_operation,
    input  logic signed [bss_pkg::VAL_W-1:0]     in_value,
    output logic [bss_pkg::STATUS_W-1:0]         res_status,
    output logic [bss_pkg::COUNT_W-1:0]          res_count,
    output logic                                 res_is_empty,
    output logic signed [bss_pkg::VAL_W-1:0]     res_largest,
    output logic signed [bss_pkg::VAL_W-1:0]     res_smallest
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Item and scan state
    logic [bss_pkg::OP_W-1:0]         op_reg, op_next;
    logic signed [bss_pkg::VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]                 held_reg, held_next;
    logic [CNT_W-1:0]                 rd_idx_reg, rd_idx_next;
    logic                             pend_reg, pend_next;
    logic [IDX_W-1:0]                 pend_idx_reg, pend_idx_next;
    logic                             found_reg, found_next;
    logic                             have_reg, have_next;
    logic signed [bss_pkg::VAL_W-1:0] hi_reg, hi_next;
    logic signed [bss_pkg::VAL_W-1:0] lo_reg, lo_next;

    // Result payload
    logic [bss_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [bss_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic                             empty_reg, empty_next;
    logic signed [bss_pkg::VAL_W-1:0] largest_reg, largest_next;
    logic signed [bss_pkg::VAL_W-1:0] smallest_reg, smallest_next;

    // Memory port signals
    logic                             mem_we;
    logic [IDX_W-1:0]                 mem_waddr;
    logic [bss_pkg::VAL_W-1:0]        mem_wdata;
    logic [bss_pkg::VAL_W-1:0]        mem_rdata;
    logic signed [bss_pkg::VAL_W-1:0] entry;

    // Decode helpers
    logic                             rd_more;
    logic                             deleting;
    logic                             hit;
    logic                             keep;
    logic                             shift_we;
    logic                             append;
    logic                             remove;
    logic                             have_fin;
    logic signed [bss_pkg::VAL_W-1:0] fin_hi;
    logic signed [bss_pkg::VAL_W-1:0] fin_lo;
    logic [CNT_W-1:0]                 new_held;
    logic [CNT_W+bss_pkg::COUNT_W-1:0] held_wide;

    bss_ram #(
        .WIDTH(bss_pkg::VAL_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(rd_idx_reg[IDX_W-1:0]),
        .rdata(mem_rdata)
    );

    assign entry    = $signed(mem_rdata);
    assign rd_more  = (rd_idx_reg < held_reg);
    assign deleting = (op_reg == bss_pkg::OP_DELETE) || (op_reg == bss_pkg::OP_DEL_FIRST);
    assign stat.scan_done = !rd_more && !pend_reg;

    // Match on the returning entry: first equal value, or position zero for delete first
    always_comb begin
        hit = 1'b0;
        if (pend_reg && !found_reg) begin
            if ((op_reg == bss_pkg::OP_INSERT) || (op_reg == bss_pkg::OP_DELETE)) begin
                hit = (entry == val_reg);
            end else if (op_reg == bss_pkg::OP_DEL_FIRST) begin
                hit = (pend_idx_reg == '0);
            end
        end
    end

    assign keep     = !(hit && deleting);
    assign shift_we = cmd.scan && pend_reg && found_reg && deleting;

    // End-of-item decisions
    assign append = (op_reg == bss_pkg::OP_INSERT) && !found_reg && (held_reg < CAP_CNT);
    assign remove = deleting && found_reg;

    always_comb begin
        if (append) begin
            new_held = held_reg + CNT_W'(1);
        end else if (remove) begin
            new_held = held_reg - CNT_W'(1);
        end else begin
            new_held = held_reg;
        end
    end

    // Fold the appended value into the running extremes
    always_comb begin
        have_fin = have_reg || append;
        fin_hi   = hi_reg;
        fin_lo   = lo_reg;
        if (append) begin
            if (!have_reg || (val_reg > hi_reg)) begin
                fin_hi = val_reg;
            end
            if (!have_reg || (val_reg < lo_reg)) begin
                fin_lo = val_reg;
            end
        end
    end

    assign held_wide = {{bss_pkg::COUNT_W{1'b0}}, new_held};

    // Memory writes: shift down during the scan, append at the end
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pend_idx_reg - IDX_W'(1);
        mem_wdata = mem_rdata;
        if (shift_we) begin
            mem_we = 1'b1;
        end else if (cmd.finish && append) begin
            mem_we    = 1'b1;
            mem_waddr = held_reg[IDX_W-1:0];
            mem_wdata = val_reg;
        end
    end

    // Next state of the scan and the result
    always_comb begin
        op_next       = op_reg;
        val_next      = val_reg;
        held_next     = held_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        have_next     = have_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        empty_next    = empty_reg;
        largest_next  = largest_reg;
        smallest_next = smallest_reg;

        if (cmd.load) begin
            op_next     = in_operation;
            val_next    = in_value;
            rd_idx_next = '0;
            pend_next   = 1'b0;
            found_next  = 1'b0;
            have_next   = 1'b0;
        end else if (cmd.scan) begin
            // Issue the next read
            pend_next     = rd_more;
            pend_idx_next = rd_idx_reg[IDX_W-1:0];
            if (rd_more) begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            // Consume the returning entry
            if (pend_reg) begin
                if (hit) begin
                    found_next = 1'b1;
                end
                if (keep) begin
                    have_next = 1'b1;
                    if (!have_reg || (entry > hi_reg)) begin
                        hi_next = entry;
                    end
                    if (!have_reg || (entry < lo_reg)) begin
                        lo_next = entry;
                    end
                end
            end
        end else if (cmd.finish) begin
            held_next     = new_held;
            count_next    = held_wide[bss_pkg::COUNT_W-1:0];
            empty_next    = (new_held == '0);
            largest_next  = have_fin ? fin_hi : '0;
            smallest_next = have_fin ? fin_lo : '0;
            unique case (op_reg)
                bss_pkg::OP_INSERT: begin
                    if (found_reg) begin
                        status_next = bss_pkg::ST_PRESENT;
                    end else if (!append) begin
                        status_next = bss_pkg::ST_FULL;
                    end else begin
                        status_next = bss_pkg::ST_OK;
                    end
                end
                bss_pkg::OP_DELETE: begin
                    status_next = found_reg ? bss_pkg::ST_OK : bss_pkg::ST_NOT_FOUND;
                end
                bss_pkg::OP_DEL_FIRST: begin
                    status_next = found_reg ? bss_pkg::ST_OK : bss_pkg::ST_EMPTY;
                end
                default: begin
                    status_next = bss_pkg::ST_OK;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            have_reg   <= 1'b0;
        end else begin
            held_reg   <= held_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            have_reg   <= have_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        pend_idx_reg <= pend_idx_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
        empty_reg    <= empty_next;
        largest_reg  <= largest_next;
        smallest_reg <= smallest_next;
    end

    assign res_status   = status_reg;
    assign res_count    = count_reg;
    assign res_is_empty = empty_reg;
    assign res_largest  = largest_reg;
    assign res_smallest = smallest_reg;

endmodule

[src/bss_ctrl.sv]
module bss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bss_pkg::dp_cmd_t  cmd,
    input  bss_pkg::dp_stat_t stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Sequence one item: capture, scan, then hand off to the output register
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[src/bounded_set_store_core.sv]
// Bounded set of distinct signed 32-bit values, stored compacted in insertion order.
// Input channel (s_valid/s_ready): s_operation selects insert, delete value or
// delete first entry; s_value is the operand. Each transfer yields exactly one
// result transfer on the m_ channel with status, count, is_empty and the
// largest and smallest live values (zero when the set is empty).
// An item scans the live entries through the entry RAM (one read port,
// one write port), one entry per cycle, compacting later entries on a delete in
// the same pass. The controller steps through capture, scan and finish; the
// finish step loads the result register and returns to idle, where the next
// item is taken.
// One item is in work at a time; the result sits in an output register, so the
// next item is accepted while an earlier result still waits for m_ready.
// If the receiver stalls, the finished item holds until the output register frees.
// Reset (aresetn low, synchronous) empties the set and drops any pending result;
// no clearing pass is needed, since only live positions are ever read.
module bounded_set_store_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bss_pkg::OP_W-1:0]             s_operation,
    input  logic signed [bss_pkg::VAL_W-1:0]     s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bss_pkg::STATUS_W-1:0]         m_status,
    output logic [bss_pkg::COUNT_W-1:0]          m_count,
    output logic                                 m_is_empty,
    output logic signed [bss_pkg::VAL_W-1:0]     m_largest,
    output logic signed [bss_pkg::VAL_W-1:0]     m_smallest
);

    bss_pkg::dp_cmd_t  cmd;
    bss_pkg::dp_stat_t stat;

    bss_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .stat   (stat)
    );

    bss_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_operation(s_operation),
        .in_value    (s_value),
        .res_status  (m_status),
        .res_count   (m_count),
        .res_is_empty(m_is_empty),
        .res_largest (m_largest),
        .res_smallest(m_smallest)
    );

endmodule

[dv/bounded_set_store_core_tb.sv]
module bounded_set_store_core_tb;

    localparam int CAPACITY      = 16;
    localparam int RANDOM_ITEMS  = 420;
    localparam int LONG_HOLD     = 300;
    localparam int TIMEOUT_UNITS = 10_000_000;

    localparam logic signed [bss_pkg::VAL_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [bss_pkg::VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [bss_pkg::STATUS_W-1:0]     status;
        logic [bss_pkg::COUNT_W-1:0]      count;
        logic                             is_empty;
        logic signed [bss_pkg::VAL_W-1:0] largest;
        logic signed [bss_pkg::VAL_W-1:0] smallest;
    } set_report_t;

    typedef struct {
        logic [bss_pkg::OP_W-1:0]         op;
        logic signed [bss_pkg::VAL_W-1:0] value;
        bit                               fixed;
        set_report_t                      want;
    } directed_row_t;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             s_valid     = 1'b0;
    logic                             s_ready;
    logic [bss_pkg::OP_W-1:0]         s_operation = bss_pkg::OP_INSERT;
    logic signed [bss_pkg::VAL_W-1:0] s_value     = '0;
    logic                             m_valid;
    logic                             m_ready     = 1'b0;
    logic [bss_pkg::STATUS_W-1:0]     m_status;
    logic [bss_pkg::COUNT_W-1:0]      m_count;
    logic                             m_is_empty;
    logic signed [bss_pkg::VAL_W-1:0] m_largest;
    logic signed [bss_pkg::VAL_W-1:0] m_smallest;

    // shadow copy of the set
    logic signed [bss_pkg::VAL_W-1:0] model_entries [CAPACITY];
    int                               model_held = 0;

    set_report_t               expected_reports [$];
    set_report_t               front_report;
    int unsigned               err_count = 0;

    // receiver hold-off requests, counted on each side
    int unsigned               sink_hold_req  = 0;
    int unsigned               sink_hold_seen = 0;
    int unsigned               sink_stall     = 0;
    int unsigned               sink_cycle     = 0;
    int unsigned               sink_gap;

    bounded_set_store_core #(.CAPACITY(CAPACITY)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_largest   (m_largest),
        .m_smallest  (m_smallest)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one operation to the shadow set and return the report it yields
    function automatic set_report_t apply_set_op(logic [bss_pkg::OP_W-1:0] op,
                                                 logic signed [bss_pkg::VAL_W-1:0] val);
        set_report_t rep;
        int hit;
        int pos;
        hit = -1;
        pos = -1;
        rep = '0;
        rep.status = bss_pkg::ST_OK;
        if (op == bss_pkg::OP_INSERT || op == bss_pkg::OP_DELETE) begin
            for (int i = 0; i < model_held; i++) begin
                if (hit < 0 && model_entries[i] == val)
                    hit = i;
            end
        end
        if (op == bss_pkg::OP_INSERT) begin
            if (hit >= 0) begin
                rep.status = bss_pkg::ST_PRESENT;
            end else if (model_held >= CAPACITY) begin
                rep.status = bss_pkg::ST_FULL;
            end else begin
                model_entries[model_held] = val;
                model_held++;
            end
        end else if (op == bss_pkg::OP_DELETE) begin
            if (hit >= 0)
                pos = hit;
            else
                rep.status = bss_pkg::ST_NOT_FOUND;
        end else if (op == bss_pkg::OP_DEL_FIRST) begin
            if (model_held == 0)
                rep.status = bss_pkg::ST_EMPTY;
            else
                pos = 0;
        end
        // compact the tail down over the removed entry
        if (pos >= 0) begin
            for (int i = pos; i + 1 < model_held; i++)
                model_entries[i] = model_entries[i + 1];
            model_held--;
        end
        rep.count    = bss_pkg::COUNT_W'(model_held);
        rep.is_empty = (model_held == 0);
        if (model_held > 0) begin
            rep.largest  = model_entries[0];
            rep.smallest = model_entries[0];
            for (int i = 1; i < model_held; i++) begin
                if (model_entries[i] > rep.largest)
                    rep.largest = model_entries[i];
                if (model_entries[i] < rep.smallest)
                    rep.smallest = model_entries[i];
            end
        end
        return rep;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Values that collide often, plus extremes and fully random ones
    function automatic logic signed [bss_pkg::VAL_W-1:0] pool_value();
        case ($urandom_range(0, 7))
            0: return VMIN;
            1: return VMAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic signed [bss_pkg::VAL_W-1:0] live_value();
        return model_entries[$urandom_range(model_held - 1, 0)];
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Offer one item, hold it until the transfer, then record what it must yield
    task automatic transfer_item(logic [bss_pkg::OP_W-1:0] op,
                                 logic signed [bss_pkg::VAL_W-1:0] val,
                                 bit fixed, set_report_t want);
        set_report_t predicted;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_set_op(op, val);
        expected_reports.push_back(fixed ? want : predicted);
    endtask

    task automatic sender_gap(int unsigned n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Receiver: random stalls, stall-free stretches, long hold-off on request
    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 1;
        if (sink_hold_seen != sink_hold_req) begin
            sink_hold_seen <= sink_hold_req;
            sink_stall     <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            m_ready    <= 1'b0;
        end else if (sink_cycle % 512 < 100) begin
            m_ready <= 1'b1;
        end else begin
            sink_gap = idle_cycles();
            sink_stall <= (sink_gap > 0) ? sink_gap - 1 : 0;
            m_ready    <= (sink_gap == 0);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(m_status), 64'd0);
            end else begin
                front_report = expected_reports.pop_front();
                if (m_status !== front_report.status)
                    report_mismatch("status", 64'(m_status), 64'(front_report.status));
                if (m_count !== front_report.count)
                    report_mismatch("count", 64'(m_count), 64'(front_report.count));
                if (m_is_empty !== front_report.is_empty)
                    report_mismatch("is_empty", 64'(m_is_empty), 64'(front_report.is_empty));
                if (m_largest !== front_report.largest)
                    report_mismatch("largest", 64'(m_largest), 64'(front_report.largest));
                if (m_smallest !== front_report.smallest)
                    report_mismatch("smallest", 64'(m_smallest), 64'(front_report.smallest));
            end
        end
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("simulation failed");
        $finish;
    end

    initial begin
        directed_row_t                    directed_rows [$];
        set_report_t                      none;
        logic [bss_pkg::OP_W-1:0]         op;
        logic signed [bss_pkg::VAL_W-1:0] val;
        bit                               filling;
        int unsigned                      done_items;
        int unsigned                      iter;
        int unsigned                      r;
        int unsigned                      gap;

        none = '0;
        // empty set: every removal path and the unused code
        directed_rows.push_back('{bss_pkg::OP_DEL_FIRST, 32'sd0, 1,
                                  '{bss_pkg::ST_EMPTY, 5'd0, 1'b1, 0, 0}});
        directed_rows.push_back('{bss_pkg::OP_DELETE, 32'sd5, 1,
                                  '{bss_pkg::ST_NOT_FOUND, 5'd0, 1'b1, 0, 0}});
        directed_rows.push_back('{bss_pkg::OP_NONE, VMIN, 1,
                                  '{bss_pkg::ST_OK, 5'd0, 1'b1, 0, 0}});
        // extremes and a duplicate
        directed_rows.push_back('{bss_pkg::OP_INSERT, VMIN, 1,
                                  '{bss_pkg::ST_OK, 5'd1, 1'b0, VMIN, VMIN}});
        directed_rows.push_back('{bss_pkg::OP_INSERT, VMAX, 1,
                                  '{bss_pkg::ST_OK, 5'd2, 1'b0, VMAX, VMIN}});
        directed_rows.push_back('{bss_pkg::OP_INSERT, VMIN, 1,
                                  '{bss_pkg::ST_PRESENT, 5'd2, 1'b0, VMAX, VMIN}});
        // fill to capacity
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sd0, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, -32'sd1, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sd1, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sh5555_5555, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'shAAAA_AAAA, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sh0000_FFFF, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'shFFFF_0000, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sd100, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, -32'sd100, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sh7FFF_FFFE, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sh8000_0001, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sh1234_5678, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'shEDCB_A987, 0, none});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sd42, 0, none});
        // full set: new value refused, present value still reported
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sd7, 1,
                                  '{bss_pkg::ST_FULL, 5'd16, 1'b0, VMAX, VMIN}});
        directed_rows.push_back('{bss_pkg::OP_INSERT, 32'sd42, 1,
                                  '{bss_pkg::ST_PRESENT, 5'd16, 1'b0, VMAX, VMIN}});
        directed_rows.push_back('{bss_pkg::OP_NONE, 32'sd42, 1,
                                  '{bss_pkg::ST_OK, 5'd16, 1'b0, VMAX, VMIN}});
        // middle delete, then drop the head
        directed_rows.push_back('{bss_pkg::OP_DELETE, 32'sd100, 0, none});
        directed_rows.push_back('{bss_pkg::OP_DEL_FIRST, 32'sd0, 0, none});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            transfer_item(directed_rows[i].op, directed_rows[i].value,
                          directed_rows[i].fixed, directed_rows[i].want);
            sender_gap(idle_cycles());
        end

        // Random part: swing between filling and draining the set
        filling    = 1'b1;
        done_items = 0;
        iter       = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (model_held >= CAPACITY)
                filling = 1'b0;
            else if (model_held == 0)
                filling = 1'b1;

            r = $urandom_range(0, 99);
            if (r < 3) begin
                op  = bss_pkg::OP_NONE;
                val = $signed($urandom);
            end else if ((filling && r < 75) || (!filling && r < 28)) begin
                op  = bss_pkg::OP_INSERT;
                val = ($urandom_range(0, 4) == 0 && model_held > 0) ? live_value()
                                                                    : pool_value();
            end else if ($urandom_range(0, 1) == 0) begin
                op  = bss_pkg::OP_DELETE;
                val = ($urandom_range(0, 3) != 0 && model_held > 0) ? live_value()
                                                                    : pool_value();
            end else begin
                op  = bss_pkg::OP_DEL_FIRST;
                val = $signed($urandom);
            end

            // hold the receiver off while items keep coming
            if (iter == 150)
                sink_hold_req <= sink_hold_req + 1;

            transfer_item(op, val, 0, none);
            if (op != bss_pkg::OP_NONE)
                done_items++;

            // let the block drain completely before going on
            if (iter == 300) begin
                s_valid <= 1'b0;
                while (expected_reports.size() != 0) @(posedge aclk);
            end else begin
                gap = ((iter % 100) < 25 || (iter >= 150 && iter < 170)) ? 0 : idle_cycles();
                sender_gap(gap);
            end
            iter++;
        end

        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (CAPACITY + 8) @(posedge aclk);

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
src/bss_pkg.sv
src/bss_ram.sv
src/bss_datapath.sv
src/bss_ctrl.sv
src/bounded_set_store_core.sv
dv/bounded_set_store_core_tb.sv
